// File: hdl/uvis_pkg.sv
package uvis_pkg;

    localparam int MAX_DEST_WIDTH  = 256;
    localparam int MAX_DEST_HEIGHT = 256;
    localparam int MAX_SRC_DIM     = 4096;

    localparam int COL_W  = $clog2(MAX_DEST_WIDTH);
    localparam int ROW_W  = $clog2(MAX_DEST_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int CELLS  = MAX_DEST_WIDTH * MAX_DEST_HEIGHT;

    localparam int CH_W      = 16;
    localparam int SRC_W     = 12;
    localparam int DIV_W     = 13;
    localparam int NUM_W     = SRC_W + CH_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam int BITS_W     = 5;
    localparam int SIZE_W     = 9;
    localparam int MAX_BITS   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 4;

    localparam logic REQ_SCATTER = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COORD_BITS  = 3'd0,
        CFG_CENTERED    = 3'd1,
        CFG_DEST_WIDTH  = 3'd2,
        CFG_DEST_HEIGHT = 3'd3,
        CFG_SRC_COLS    = 3'd4,
        CFG_SRC_ROWS    = 3'd5,
        CFG_HAS_ALPHA   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [BITS_W-1:0] coord_bits;
        logic              centered;
        logic [SIZE_W-1:0] dest_width;
        logic [SIZE_W-1:0] dest_height;
        logic [DIV_W-1:0]  src_cols;
        logic [DIV_W-1:0]  src_rows;
        logic              has_alpha;
    } cfg_t;

    typedef struct packed {
        logic              is_read;
        logic [ADDR_W-1:0] addr;
        logic [CH_W-1:0]   alpha;
        logic [SRC_W-1:0]  src_x;
        logic [SRC_W-1:0]  src_y;
    } job_t;

    typedef struct packed {
        logic [CH_W-1:0] x;
        logic [CH_W-1:0] y;
        logic [CH_W-1:0] a;
    } cell_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// File: hdl/uvis_front.sv
module uvis_front
    import uvis_pkg::*;
(
    input  cfg_t                 cfg,
    input  back_status_t         status,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [SRC_W-1:0]     src_x,
    input  logic [SRC_W-1:0]     src_y,
    input  logic [CH_W-1:0]      u_in,
    input  logic [CH_W-1:0]      v_in,
    input  logic [CH_W-1:0]      alpha_in,
    input  logic [COL_W-1:0]     read_col,
    input  logic [ROW_W-1:0]     read_row,
    output logic                 push_valid,
    output job_t                 push_job,
    input  logic                 push_ready
);

    // cell index rounded down, values between -1 and 0 go to 0, offset already applied
    function automatic logic signed [17:0] axis_cell(
        input logic [CH_W-1:0]   coord,
        input logic [BITS_W-1:0] bits,
        input logic              ctr,
        input logic [SIZE_W-1:0] size
    );
        logic [31:0]        scaled;
        logic signed [17:0] diff;
        logic signed [17:0] off;
        logic signed [17:0] t;
        scaled = {16'd0, coord} << bits;
        diff   = (18'sd1 <<< bits) - $signed({9'd0, size}) + 18'sd1;
        off    = ctr ? (diff >>> 1) : 18'sd0;
        t      = $signed({2'b00, scaled[31:16]}) - off;
        if (t == -18'sd1 && scaled[15:0] != 16'd0)
            return 18'sd0;
        return t;
    endfunction

    logic [BITS_W-1:0]  bits_eff;
    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic signed [17:0] col_c;
    logic signed [17:0] row_c;
    logic               hit;

    always_comb
    begin
        bits_eff = (cfg.coord_bits > BITS_W'(MAX_BITS)) ? BITS_W'(MAX_BITS) : cfg.coord_bits;
        w_eff    = (cfg.dest_width > SIZE_W'(MAX_DEST_WIDTH))
                   ? SIZE_W'(MAX_DEST_WIDTH) : cfg.dest_width;
        h_eff    = (cfg.dest_height > SIZE_W'(MAX_DEST_HEIGHT))
                   ? SIZE_W'(MAX_DEST_HEIGHT) : cfg.dest_height;
        col_c    = axis_cell(u_in, bits_eff, cfg.centered, w_eff);
        row_c    = axis_cell(v_in, bits_eff, cfg.centered, h_eff);
        hit      = (col_c >= 18'sd0) && (col_c < $signed({9'd0, w_eff}))
                && (row_c >= 18'sd0) && (row_c < $signed({9'd0, h_eff}));
    end

    always_comb
    begin
        in_ready         = push_ready && !status.clearing;
        push_valid       = in_valid && in_ready && ((req_type == REQ_READ) || hit);
        push_job.is_read = (req_type == REQ_READ);
        push_job.addr    = (req_type == REQ_READ) ? {read_row, read_col}
                                                  : {row_c[ROW_W-1:0], col_c[COL_W-1:0]};
        push_job.alpha   = cfg.has_alpha ? alpha_in : {CH_W{1'b1}};
        push_job.src_x   = src_x;
        push_job.src_y   = src_y;
    end

endmodule

// File: hdl/uvis_fifo.sv
module uvis_fifo
    import uvis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  job_t push_job,
    output logic push_ready,
    output logic pop_valid,
    output job_t pop_job,
    input  logic pop_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    always_comb
    begin
        push_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
        pop_valid   = (count_reg != '0);
        pop_job     = slot_reg[rd_ptr_reg];
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");
`endif

endmodule

// File: hdl/uvis_div.sv
module uvis_div
    import uvis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SRC_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [CH_W-1:0]  quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DIV_W-2:0]     rem_reg;
    logic [DIV_W-2:0]     rem_next;
    logic [DIV_W-1:0]     den_reg;
    logic [CH_W-1:0]      quo_reg;
    logic [DIV_W-1:0]     trial;
    logic [DIV_W-1:0]     diff;
    logic                 ge;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - den_reg;
        ge       = (trial >= den_reg);
        rem_next = ge ? diff[DIV_W-2:0] : trial[DIV_W-2:0];
        busy     = busy_reg;
        quotient = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {dividend, {CH_W{1'b0}}};
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[CH_W-2:0], ge};
        end
    end

endmodule

// File: hdl/uvis_back.sv
module uvis_back
    import uvis_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            pop_valid,
    input  job_t            pop_job,
    output logic            pop_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CH_W-1:0] out_x_coord,
    output logic [CH_W-1:0] out_y_coord,
    output logic [CH_W-1:0] out_alpha,
    output back_status_t    status
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_SCAT  = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] clr_next;
    job_t              job_reg;
    cell_t             mem [CELLS];
    cell_t             rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    cell_t             mem_wdata;
    logic              pop;
    logic              out_free;
    logic              out_load;
    logic              out_valid_reg;
    logic              out_valid_next;
    cell_t             out_reg;
    logic [DIV_W-1:0]  den_x;
    logic [DIV_W-1:0]  den_y;
    logic              div_start;
    logic              div_x_busy;
    logic              div_y_busy;
    logic [CH_W-1:0]   quo_x;
    logic [CH_W-1:0]   quo_y;

    always_comb
    begin
        den_x = (cfg.src_cols == '0) ? DIV_W'(1)
              : (cfg.src_cols > DIV_W'(MAX_SRC_DIM)) ? DIV_W'(MAX_SRC_DIM) : cfg.src_cols;
        den_y = (cfg.src_rows == '0) ? DIV_W'(1)
              : (cfg.src_rows > DIV_W'(MAX_SRC_DIM)) ? DIV_W'(MAX_SRC_DIM) : cfg.src_rows;
    end

    uvis_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pop_job.src_x),
        .divisor  (den_x),
        .busy     (div_x_busy),
        .quotient (quo_x)
    );

    uvis_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pop_job.src_y),
        .divisor  (den_y),
        .busy     (div_y_busy),
        .quotient (quo_y)
    );

    always_comb
    begin
        pop_ready       = (state_reg == S_IDLE);
        pop             = pop_valid && pop_ready;
        div_start       = pop && !pop_job.is_read;
        out_free        = !out_valid_reg || out_ready;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = job_reg.addr;
        mem_wdata       = '0;
        clr_next        = clr_reg;
        state_next      = state_reg;
        status.clearing = (state_reg == S_CLEAR);

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {ADDR_W{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (pop)
                    state_next = pop_job.is_read ? S_READ : S_SCAT;
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    mem_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAT:
            begin
                if (!div_x_busy)
                begin
                    mem_we     = (rd_data_reg.a < job_reg.alpha);
                    mem_wdata  = '{x: quo_x, y: quo_y, a: job_reg.alpha};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
        out_valid      = out_valid_reg;
        out_x_coord    = out_reg.x;
        out_y_coord    = out_reg.y;
        out_alpha      = out_reg.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= pop_job;
        if (out_load)
            out_reg <= rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (pop)
            rd_data_reg <= mem[pop_job.addr];
    end

`ifndef NO_ASSERTIONS
    a_pop_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_READ) || (state_reg == S_SCAT))
        else $error("popped item not dispatched");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_x_busy == div_y_busy)
        else $error("dividers out of step");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_READ))
        else $error("result raised outside a read");
`endif

endmodule

// File: hdl/uv_map_inverse_scatter_core.sv
// UV map inverse scatter.
// Input channel in_valid/in_ready carries one item: req_type 0 scatters a
// source pixel (src_x, src_y, u_in, v_in, alpha_in) into the 256x256
// destination store; req_type 1 reads and clears cell (read_col, read_row).
// Output channel out_valid/out_ready returns one item per read, none per
// scatter. Configuration is a write port (cfg_we, cfg_addr, cfg_data).
// Front end maps the UV position to a cell in the accept cycle and drops
// scatters that fall outside; a four-entry queue feeds the back end.
// Back end: takes one queue entry at a time; a scatter waits for the
// 28-step restoring dividers for the normalized source position.
// A read passes the queue, read-data and result registers to out_valid.
// After reset the store is zeroed one cell per cycle over 65536 cells;
// in_ready stays low during that pass, configuration writes are taken.
// A stalled receiver holds the result register; the back end waits, the
// queue fills and in_ready drops once its four entries are taken.
module uv_map_inverse_scatter_core
    import uvis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [SRC_W-1:0]      src_x,
    input  logic [SRC_W-1:0]      src_y,
    input  logic [CH_W-1:0]       u_in,
    input  logic [CH_W-1:0]       v_in,
    input  logic [CH_W-1:0]       alpha_in,
    input  logic [COL_W-1:0]      read_col,
    input  logic [ROW_W-1:0]      read_row,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CH_W-1:0]       out_x_coord,
    output logic [CH_W-1:0]       out_y_coord,
    output logic [CH_W-1:0]       out_alpha
);

    cfg_t         cfg_reg;
    back_status_t status;
    logic         push_valid;
    logic         push_ready;
    job_t         push_job;
    logic         pop_valid;
    logic         pop_ready;
    job_t         pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coord_bits  <= BITS_W'(8);
            cfg_reg.centered    <= 1'b0;
            cfg_reg.dest_width  <= SIZE_W'(256);
            cfg_reg.dest_height <= SIZE_W'(256);
            cfg_reg.src_cols    <= DIV_W'(4096);
            cfg_reg.src_rows    <= DIV_W'(4096);
            cfg_reg.has_alpha   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_COORD_BITS:  cfg_reg.coord_bits  <= cfg_data[BITS_W-1:0];
                CFG_CENTERED:    cfg_reg.centered    <= cfg_data[0];
                CFG_DEST_WIDTH:  cfg_reg.dest_width  <= cfg_data[SIZE_W-1:0];
                CFG_DEST_HEIGHT: cfg_reg.dest_height <= cfg_data[SIZE_W-1:0];
                CFG_SRC_COLS:    cfg_reg.src_cols    <= cfg_data[DIV_W-1:0];
                CFG_SRC_ROWS:    cfg_reg.src_rows    <= cfg_data[DIV_W-1:0];
                CFG_HAS_ALPHA:   cfg_reg.has_alpha   <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    uvis_front u_front (
        .cfg        (cfg_reg),
        .status     (status),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .src_x      (src_x),
        .src_y      (src_y),
        .u_in       (u_in),
        .v_in       (v_in),
        .alpha_in   (alpha_in),
        .read_col   (read_col),
        .read_row   (read_row),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    uvis_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    uvis_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pop_valid   (pop_valid),
        .pop_job     (pop_job),
        .pop_ready   (pop_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x_coord (out_x_coord),
        .out_y_coord (out_y_coord),
        .out_alpha   (out_alpha),
        .status      (status)
    );

endmodule
